// File: sv/dotq_pkg.sv
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared sizes, opcodes, result kinds and controller/datapath interface types
// for the deadline ordered timeout queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

    localparam int DEPTH       = 16;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int DL_W        = 64;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 72;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [KIND_W-1:0] K_ARM      = 3'd0;
    localparam logic [KIND_W-1:0] K_TIMEDOUT = 3'd1;
    localparam logic [KIND_W-1:0] K_IDLE     = 3'd2;
    localparam logic [KIND_W-1:0] K_FULL     = 3'd3;
    localparam logic [KIND_W-1:0] K_REMOVED  = 3'd4;
    localparam logic [KIND_W-1:0] K_NOTFOUND = 3'd5;

    typedef struct packed {
        logic capture;    // latch the input beat
        logic calc;       // deadline = now + timeout, saturating
        logic flag;       // register per-entry compare flags
        logic apply;      // insert or remove, load result
        logic chk_pop;    // emit head as timed out, drop it
        logic chk_final;  // emit arm of head or idle
    } dotq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]  in_op;
        logic             out_free;
        logic             head_due;
        logic [OCC_W-1:0] occ;
    } dotq_stat_t;

endpackage

// File: sv/dotq_ctrl.sv
// ----------------------------------------------------------------------------
// dotq_ctrl
// Sequencer: steps an add through deadline calc, compare, update and result
// issue (a remove skips the calc), and loops over expired entries on a check.
// ----------------------------------------------------------------------------
module dotq_ctrl
    import dotq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dotq_stat_t stat,
    output dotq_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_FLAG  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (stat.in_op)
                        OP_ADD:    state_next = S_CALC;
                        OP_REMOVE: state_next = S_FLAG;
                        OP_CHECK:  state_next = S_CHECK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_FLAG;
            end
            S_FLAG:
            begin
                cmd.flag   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (stat.out_free)
                begin
                    if (stat.head_due)
                    begin
                        cmd.chk_pop = 1'b1;
                    end
                    else
                    begin
                        cmd.chk_final = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/dotq_dpath.sv
// ----------------------------------------------------------------------------
// dotq_dpath
// Sorted row of entry cells with per-cell compare flags, occupancy count,
// deadline adder and the output register.
// ----------------------------------------------------------------------------
module dotq_dpath
    import dotq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  dotq_cmd_t              cmd,
    output dotq_stat_t             stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic [KIND_W-1:0]      out_kind,
    output logic                   out_last
);

    logic [OP_W-1:0]  op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [DL_W-1:0]  tmo_reg;
    logic [DL_W-1:0]  now_reg;
    logic [DL_W-1:0]  dl_reg;
    logic [DL_W:0]    dl_sum;

    logic [DEPTH-1:0] le_reg;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] le_next;
    logic [DEPTH-1:0] match_next;
    logic [DEPTH-1:0] hit;

    logic [ID_W-1:0]  cell_id_reg   [DEPTH];
    logic [ID_W-1:0]  cell_id_next  [DEPTH];
    logic [DL_W-1:0]  cell_dl_reg   [DEPTH];
    logic [DL_W-1:0]  cell_dl_next  [DEPTH];
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [KIND_W-1:0] out_kind_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [DL_W-1:0]   out_dl_reg;
    logic [DL_W-1:0]   out_dl_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_load;
    logic              full;
    logic              found;
    logic              run;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign full     = (occ_reg == OCC_W'(DEPTH));
    assign dl_sum   = {1'b0, now_reg} + {1'b0, tmo_reg};

    assign stat.in_op    = in_data[OP_W-1:0];
    assign stat.out_free = out_free;
    assign stat.head_due = (occ_reg != '0) && (cell_dl_reg[0] <= now_reg);
    assign stat.occ      = occ_reg;

    // Only entries below the occupancy count take part in a compare.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le_next[i]    = (OCC_W'(i) < occ_reg) && (cell_dl_reg[i] <= dl_reg);
            match_next[i] = (OCC_W'(i) < occ_reg) && (cell_id_reg[i] == id_reg);
        end
    end

    always_comb
    begin
        run = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            run    = run | match_reg[i];
            hit[i] = run;
        end
        found = run;
    end

    always_comb
    begin
        cell_id_next  = cell_id_reg;
        cell_dl_next  = cell_dl_reg;
        occ_next      = occ_reg;
        out_load      = 1'b0;
        out_kind_next = out_kind_reg;
        out_id_next   = out_id_reg;
        out_dl_next   = out_dl_reg;
        out_last_next = out_last_reg;

        if (cmd.apply)
        begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            out_id_next   = id_reg;
            if (op_reg == OP_ADD)
            begin
                out_dl_next = dl_reg;
                if (full)
                begin
                    out_kind_next = K_FULL;
                end
                else
                begin
                    out_kind_next = K_ARM;
                    occ_next      = occ_reg + 1'b1;
                    // thermometer le: keep below, new at the edge, shift up after
                    if (!le_reg[0])
                    begin
                        cell_id_next[0] = id_reg;
                        cell_dl_next[0] = dl_reg;
                    end
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (!le_reg[i])
                        begin
                            if (le_reg[i-1])
                            begin
                                cell_id_next[i] = id_reg;
                                cell_dl_next[i] = dl_reg;
                            end
                            else
                            begin
                                cell_id_next[i] = cell_id_reg[i-1];
                                cell_dl_next[i] = cell_dl_reg[i-1];
                            end
                        end
                    end
                end
            end
            else
            begin
                out_dl_next   = '0;
                out_kind_next = found ? K_REMOVED : K_NOTFOUND;
                if (found)
                begin
                    occ_next = occ_reg - 1'b1;
                end
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    if (hit[i])
                    begin
                        cell_id_next[i] = cell_id_reg[i+1];
                        cell_dl_next[i] = cell_dl_reg[i+1];
                    end
                end
            end
        end
        else if (cmd.chk_pop)
        begin
            out_load      = 1'b1;
            out_kind_next = K_TIMEDOUT;
            out_id_next   = cell_id_reg[0];
            out_dl_next   = cell_dl_reg[0];
            out_last_next = 1'b0;
            occ_next      = occ_reg - 1'b1;
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                cell_id_next[i] = cell_id_reg[i+1];
                cell_dl_next[i] = cell_dl_reg[i+1];
            end
        end
        else if (cmd.chk_final)
        begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            if (occ_reg == '0)
            begin
                out_kind_next = K_IDLE;
                out_id_next   = '0;
                out_dl_next   = '0;
            end
            else
            begin
                out_kind_next = K_ARM;
                out_id_next   = cell_id_reg[0];
                out_dl_next   = cell_dl_reg[0];
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data[OP_W-1:0];
            id_reg  <= in_data[OP_W +: ID_W];
            tmo_reg <= in_data[OP_W+ID_W +: DL_W];
            now_reg <= in_data[OP_W+ID_W+DL_W +: DL_W];
        end
        if (cmd.calc)
        begin
            dl_reg <= dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];
        end
        if (cmd.flag)
        begin
            le_reg    <= le_next;
            match_reg <= match_next;
        end
        cell_id_reg  <= cell_id_next;
        cell_dl_reg  <= cell_dl_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_dl_reg   <= out_dl_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {out_dl_reg, out_id_reg};

endmodule

// File: sv/deadline_ordered_timeout_queue.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timeout_queue
// Add: accept, deadline add, compare and update, then the result is loaded.
// Remove: accept, compare, update. Check: a result per expired entry, one per
// cycle while the output is taken, then a final one. One operation at a time; the
// next beat is accepted as soon as the final result sits in the output register.
// Reset empties the queue and drops any pending result; entries keep no reset.
// ----------------------------------------------------------------------------
module deadline_ordered_timeout_queue
    import dotq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] opcode, [9:2] request_id, [73:10] timeout_ticks, [137:74] now
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] request_id_res, [71:8] deadline
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    dotq_cmd_t  cmd;
    dotq_stat_t stat;

    dotq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dotq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.occ <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply || cmd.chk_pop || cmd.chk_final) |-> stat.out_free)
        else $error("result loaded over a pending beat");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk_pop |=> (stat.occ + 1'b1) == $past(stat.occ))
        else $error("pop did not shrink queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk_pop |-> stat.occ != '0)
        else $error("pop from empty queue");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadline ordered timeout queue. A short table of
// directed requests is followed by phases of random adds, removes and checks.
// A shadow copy of the sorted queue predicts every result. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb;
    import dotq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int MAX_PRINTS     = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PAD_W          = IN_TDATA_W - 2 * DL_W - ID_W - OP_W;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [DL_W-1:0] MAX_TICKS = '1;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int MODE_NOISY = 3;
    localparam int MODE_FLUSH = 4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] tmo;
        logic [DL_W-1:0] now;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [DL_W-1:0]   dl;
        logic              last;
    } timer_rsp_t;

    typedef struct packed {
        timer_req_t req;
        logic       typed;
        timer_rsp_t rsp;
    } table_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // shadow of the pending list, sorted by deadline
    logic [ID_W-1:0] shadow_ids [DEPTH];
    logic [DL_W-1:0] shadow_dls [DEPTH];
    int              shadow_count = 0;
    timer_rsp_t      awaited_rsps [$];
    int              fail_count = 0;
    int              idle_cycles = 0;
    bit              steady = 1'b0;
    logic [DL_W-1:0] uptime = '0;

    deadline_ordered_timeout_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic timer_rsp_t make_rsp(input logic [KIND_W-1:0] kind,
                                            input logic [ID_W-1:0] id,
                                            input logic [DL_W-1:0] dl,
                                            input logic last);
        timer_rsp_t r;
        r.kind = kind;
        r.id   = id;
        r.dl   = dl;
        r.last = last;
        return r;
    endfunction

    function automatic table_row_t row(input logic [OP_W-1:0] op,
                                       input logic [ID_W-1:0] id,
                                       input logic [DL_W-1:0] tmo,
                                       input logic [DL_W-1:0] now,
                                       input logic typed,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] rid,
                                       input logic [DL_W-1:0] dl);
        table_row_t t;
        t.req.op  = op;
        t.req.id  = id;
        t.req.tmo = tmo;
        t.req.now = now;
        t.typed   = typed;
        t.rsp     = make_rsp(kind, rid, dl, 1'b1);
        return t;
    endfunction

    function automatic void drop_slot(input int pos);
        for (int i = pos; i < shadow_count - 1; i++)
        begin
            shadow_ids[i] = shadow_ids[i + 1];
            shadow_dls[i] = shadow_dls[i + 1];
        end
        shadow_count--;
    endfunction

    // Updates the shadow queue and queues the results of one accepted beat.
    function automatic void predict_timer_op(input timer_req_t req);
        logic            carry;
        logic [DL_W-1:0] dl;
        int              pos;
        case (req.op)
            OP_ADD:
            begin
                {carry, dl} = {1'b0, req.now} + {1'b0, req.tmo};
                if (carry)
                    dl = MAX_TICKS;
                if (shadow_count >= DEPTH)
                    awaited_rsps.push_back(make_rsp(K_FULL, req.id, dl, 1'b1));
                else
                begin
                    // behind every entry due at or before it
                    pos = 0;
                    while (pos < shadow_count && shadow_dls[pos] <= dl)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_ids[i] = shadow_ids[i - 1];
                        shadow_dls[i] = shadow_dls[i - 1];
                    end
                    shadow_ids[pos] = req.id;
                    shadow_dls[pos] = dl;
                    shadow_count++;
                    awaited_rsps.push_back(make_rsp(K_ARM, req.id, dl, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < shadow_count && shadow_ids[pos] != req.id)
                    pos++;
                if (pos < shadow_count)
                begin
                    drop_slot(pos);
                    awaited_rsps.push_back(make_rsp(K_REMOVED, req.id, '0, 1'b1));
                end
                else
                    awaited_rsps.push_back(make_rsp(K_NOTFOUND, req.id, '0, 1'b1));
            end
            OP_CHECK:
            begin
                while (shadow_count > 0 && shadow_dls[0] <= req.now)
                begin
                    awaited_rsps.push_back(make_rsp(K_TIMEDOUT, shadow_ids[0],
                                                    shadow_dls[0], 1'b0));
                    drop_slot(0);
                end
                if (shadow_count == 0)
                    awaited_rsps.push_back(make_rsp(K_IDLE, '0, '0, 1'b1));
                else
                    awaited_rsps.push_back(make_rsp(K_ARM, shadow_ids[0],
                                                    shadow_dls[0], 1'b1));
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic timer_req_t random_req(input int mode);
        timer_req_t req;
        int         roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  req.op = OP_ADD;
            MODE_DRAIN: req.op = roll < 20 ? OP_ADD : (roll < 60 ? OP_CHECK : OP_REMOVE);
            default:    req.op = roll < 45 ? OP_ADD : (roll < 75 ? OP_CHECK : OP_REMOVE);
        endcase

        // uptime mostly creeps forward; now and then it jumps
        roll = $urandom_range(0, 99);
        if (mode == MODE_NOISY || roll < 4)
            uptime = {$urandom, $urandom};
        else if (roll < 7)
            uptime = MAX_TICKS - DL_W'($urandom_range(0, 200));
        else
            uptime = uptime + DL_W'($urandom_range(0, 40));
        req.now = uptime;

        roll = $urandom_range(0, 99);
        if (roll < 60)
            req.tmo = DL_W'($urandom_range(0, 150));
        else if (roll < 80)
            req.tmo = DL_W'($urandom_range(0, 3000));
        else if (roll < 90)
            req.tmo = {$urandom, $urandom};
        else if (roll < 95)
            req.tmo = MAX_TICKS;
        else
            req.tmo = '0;

        roll = $urandom_range(0, 99);
        if (req.op == OP_REMOVE && shadow_count > 0 && roll < 70)
            req.id = shadow_ids[$urandom_range(0, shadow_count - 1)];
        else if (mode != MODE_NOISY && roll < 75)
            req.id = ID_W'($urandom_range(0, 15));
        else
            req.id = ID_W'($urandom_range(0, 255));
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Drives one request beat, waits for it to be taken, then predicts.
    task automatic send_req(input timer_req_t req, input logic typed,
                            input timer_rsp_t rsp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, req.now, req.tmo, req.id, req.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_timer_op(req);
        if (typed)
        begin
            void'(awaited_rsps.pop_back());
            awaited_rsps.push_back(rsp);
        end
    endtask

    initial
    begin : sink_pacing
        int hold;
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            if (hold == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        timer_rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_rsps.size() == 0)
                report_mismatch($sformatf("unexpected beat kind %0d id %0d",
                                          m_axis_tuser, m_axis_tdata[ID_W-1:0]));
            else
            begin
                want = awaited_rsps.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                                              m_axis_tuser, want.kind));
                if (m_axis_tdata[ID_W-1:0] !== want.id)
                    report_mismatch($sformatf("id %0d, want %0d",
                                              m_axis_tdata[ID_W-1:0], want.id));
                if (m_axis_tdata[ID_W +: DL_W] !== want.dl)
                    report_mismatch($sformatf("deadline %h, want %h",
                                              m_axis_tdata[ID_W +: DL_W], want.dl));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        table_row_t rows [$];
        timer_rsp_t none;
        timer_req_t req;
        timer_req_t junk;
        int         sent;
        int         phase;
        int         mode;
        int         span;

        none = '0;
        rows.push_back(row(OP_CHECK, 8'h00, '0, '0, 1'b1, K_IDLE, 8'h00, '0));
        rows.push_back(row(OP_REMOVE, 8'h5A, '0, '0, 1'b1, K_NOTFOUND, 8'h5A, '0));
        // saturating deadlines
        rows.push_back(row(OP_ADD, 8'hFF, MAX_TICKS, MAX_TICKS, 1'b1, K_ARM, 8'hFF, MAX_TICKS));
        rows.push_back(row(OP_ADD, 8'h00, '0, '0, 1'b1, K_ARM, 8'h00, '0));
        // equal deadlines keep arrival order; id 1 twice
        rows.push_back(row(OP_ADD, 8'h01, 64'd100, 64'd0, 1'b1, K_ARM, 8'h01, 64'd100));
        rows.push_back(row(OP_ADD, 8'h02, 64'd60, 64'd40, 1'b1, K_ARM, 8'h02, 64'd100));
        rows.push_back(row(OP_ADD, 8'h01, 64'd50, 64'd50, 1'b1, K_ARM, 8'h01, 64'd100));
        rows.push_back(row(OP_ADD, 8'hAA, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                           1'b1, K_ARM, 8'hAA, MAX_TICKS));
        rows.push_back(row(OP_ADD, 8'h03, 64'd2, MAX_TICKS - 1, 1'b1, K_ARM, 8'h03, MAX_TICKS));
        rows.push_back(row(OP_ADD, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1555_5555_5555_5555,
                           1'b1, K_ARM, 8'h55, 64'hBFFF_FFFF_FFFF_FFFF));
        // only the earliest id 1 goes
        rows.push_back(row(OP_REMOVE, 8'h01, '0, '0, 1'b1, K_REMOVED, 8'h01, '0));
        rows.push_back(row(OP_CHECK, 8'h00, '0, 64'd99, 1'b0, K_ARM, 8'h00, '0));
        rows.push_back(row(OP_UNUSED, 8'h3C, 64'd7, 64'd7, 1'b0, K_ARM, 8'h00, '0));
        rows.push_back(row(OP_CHECK, 8'hC3, 64'd5, 64'd100, 1'b0, K_ARM, 8'h00, '0));
        rows.push_back(row(OP_REMOVE, 8'hAA, '0, '0, 1'b1, K_REMOVED, 8'hAA, '0));
        rows.push_back(row(OP_CHECK, 8'h00, '0, MAX_TICKS, 1'b0, K_ARM, 8'h00, '0));
        rows.push_back(row(OP_CHECK, 8'hFF, MAX_TICKS, MAX_TICKS, 1'b1, K_IDLE, 8'h00, '0));
        rows.push_back(row(OP_REMOVE, 8'hFF, '0, '0, 1'b1, K_NOTFOUND, 8'hFF, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_req(rows[r].req, rows[r].typed, rows[r].rsp);

        // first a fill well past full, then a flush that empties it
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
            begin
                mode = MODE_FILL;
                span = 20;
            end
            else if (phase == 1)
            begin
                mode = MODE_FLUSH;
                span = 1;
            end
            else
            begin
                mode = $urandom_range(MODE_FILL, MODE_FLUSH);
                span = (mode == MODE_FLUSH) ? 1 : $urandom_range(10, 40);
            end
            steady = (phase > 1) && ($urandom_range(0, 3) == 0);
            for (int k = 0; k < span; k++)
            begin
                req = random_req(mode);
                if (mode == MODE_FLUSH)
                begin
                    req.op  = OP_CHECK;
                    req.now = MAX_TICKS;
                end
                if ($urandom_range(0, 49) == 0)
                begin
                    junk    = req;
                    junk.op = OP_UNUSED;
                    send_req(junk, 1'b0, none);
                end
                send_req(req, 1'b0, none);
                sent++;
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
